FILE: hdl/bcc_pkg.sv
// Shared constants, types and functions for the brine conductivity classifier.
// No dependencies.
`default_nettype none
package bcc_pkg;

  localparam int unsigned AdcBits   = 12;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CompShift = 20;

  // divider geometry: numerator, denominator and quotient widths
  localparam int unsigned DivNumW = CompShift + AdcBits + 17;  // 49
  localparam int unsigned DivDenW = 41;
  localparam int unsigned DivQW   = 17;
  localparam int unsigned DivExtW = DivDenW + DivQW;

  localparam logic [AdcBits-1:0] AdcFullScale = {AdcBits{1'b1}};

  localparam logic [15:0] Sat16    = 16'hFFFF;
  localparam logic [13:0] CondGain = 14'd16000;

  // configuration register indexes
  localparam logic [2:0] RegTempCoef  = 3'd0;
  localparam logic [2:0] RegRefTemp   = 3'd1;
  localparam logic [2:0] RegNoiseThr  = 3'd2;
  localparam logic [2:0] RegCellConst = 3'd3;
  localparam logic [2:0] RegSeriesRes = 3'd4;
  localparam logic [2:0] RegSupply    = 3'd5;

  typedef enum logic [2:0] {
    CLASS_50G   = 3'd0,
    CLASS_80G   = 3'd1,
    CLASS_100G  = 3'd2,
    CLASS_150G  = 3'd3,
    CLASS_300G  = 3'd4,
    CLASS_400G  = 3'd5,
    CLASS_UNKNOWN = 3'd6
  } brine_class_e;

  typedef struct packed {
    logic bad;  // compensation not positive
    logic dry;  // below noise threshold
    logic sat;  // voltage at/above supply or shorted divider
  } bcc_flags_t;

  // band correction, first matching band wins (units 1/16 mS/cm)
  function automatic logic [16:0] correct_band(input logic [16:0] c);
    logic [16:0] r;
    r = c;
    if (c >= 17'd1312 && c <= 17'd1488)      r = c - 17'd96;
    else if (c >= 17'd1488 && c <= 17'd1600) r = c + 17'd197;
    else if (c >= 17'd1584 && c <= 17'd1760) r = c + 17'd352;
    else if (c >= 17'd1760 && c <= 17'd1904) r = c + 17'd800;
    else if (c >= 17'd1920 && c <= 17'd2000) r = c + 17'd1763;
    else if (c >= 17'd2000 && c <= 17'd2160) r = c + 17'd1874;
    return r;
  endfunction

  function automatic brine_class_e classify(input logic [15:0] c);
    brine_class_e k;
    k = CLASS_UNKNOWN;
    if (c >= 16'd1120 && c < 16'd1440)      k = CLASS_50G;
    else if (c >= 16'd1440 && c < 16'd1842) k = CLASS_80G;
    else if (c >= 16'd1842 && c < 16'd2332) k = CLASS_100G;
    else if (c >= 16'd2332 && c < 16'd3159) k = CLASS_150G;
    else if (c >= 16'd3159 && c < 16'd3712) k = CLASS_300G;
    else if (c >= 16'd3712 && c <= 16'd4080) k = CLASS_400G;
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/brine_conductivity_classifier.sv
// Brine conductivity classifier top level: config registers, arithmetic stages, output.
// Depends on bcc_pkg and bcc_udiv.
// Path: S1-S4, divider 1, S5-S6, divider 2, S7, output register; the two bit-per-stage
// dividers set the depth. Throughput: one transaction per cycle while not stalled.
// A stall on the output freezes the whole pipe; nothing is dropped or repeated.
// Reset (async, active low) clears valid bits and loads config defaults.
`default_nettype none
module brine_conductivity_classifier
  import bcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [11:0] adc_sample, [23:12] temp_reading
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [15:0] conductivity, [18:16] brine_class,
                                          // [19] class_known, [20] out_of_range, rest 0
);

  // ---------------- configuration ----------------
  logic [15:0] temp_coef_q;
  logic [11:0] ref_temp_q;
  logic [16:0] noise_thr_q;
  logic [15:0] cell_const_q;
  logic [19:0] series_res_q;
  logic [16:0] supply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q  <= 16'd1311;
      ref_temp_q   <= 12'd400;
      noise_thr_q  <= 17'd655;
      cell_const_q <= 16'd1800;
      series_res_q <= 20'd10000;
      supply_q     <= 17'd108134;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTempCoef:  temp_coef_q  <= cfg_data_i[15:0];
        RegRefTemp:   ref_temp_q   <= cfg_data_i[11:0];
        RegNoiseThr:  noise_thr_q  <= cfg_data_i[16:0];
        RegCellConst: cell_const_q <= cfg_data_i[15:0];
        RegSeriesRes: series_res_q <= cfg_data_i[19:0];
        RegSupply:    supply_q     <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless the output holds an untaken result
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- S1: capture, temperature delta ----------------
  logic               v1_q;
  logic [11:0]        adc1_q;
  logic signed [12:0] dt1_q;

  // ---------------- S2: products ----------------
  logic               v2_q;
  logic [28:0]        vs2_q;    // adc * supply
  logic signed [29:0] adt2_q;   // alpha * dT

  // ---------------- S3: compensation ----------------
  logic               v3_q;
  logic [28:0]        vs3_q;
  logic signed [30:0] comp3_q;

  // ---------------- S4: divider operands ----------------
  logic               v4_q;
  logic [DivNumW-1:0] num4_q;
  logic [DivDenW-1:0] den4_q;
  bcc_flags_t         fl4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adc1_q  <= s_axis_tdata[11:0];
      dt1_q   <= $signed({s_axis_tdata[23], s_axis_tdata[23:12]}) -
                 $signed({ref_temp_q[11], ref_temp_q});
      vs2_q   <= adc1_q * supply_q;
      adt2_q  <= $signed({1'b0, temp_coef_q}) * dt1_q;
      vs3_q   <= vs2_q;
      comp3_q <= $signed(31'(1) <<< CompShift) + 31'(adt2_q);
      num4_q  <= {vs3_q, {CompShift{1'b0}}};
      // positive compensation fits 29 bits; times the converter full scale
      den4_q  <= comp3_q[28:0] * AdcFullScale;
      fl4_q   <= '{bad: (comp3_q <= 0), dry: 1'b0, sat: 1'b0};
    end
  end

  // ---------------- divider 1: compensated voltage ----------------
  logic             d1_v;
  logic [DivQW-1:0] d1_q;
  logic             d1_ovf;
  bcc_flags_t       d1_fl;

  bcc_udiv u_div_volt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num4_q),
    .den_i   (den4_q),
    .side_i  (fl4_q),
    .valid_o (d1_v),
    .quot_o  (d1_q),
    .ovf_o   (d1_ovf),
    .side_o  (d1_fl)
  );

  // ---------------- S5: range checks, difference, K*v ----------------
  logic        v5_q;
  bcc_flags_t  fl5_q;
  logic [16:0] diff5_q;
  logic [32:0] kv5_q;

  // ---------------- S6: conductivity divider operands ----------------
  logic               v6_q;
  bcc_flags_t         fl6_q;
  logic [DivNumW-1:0] num6_q;
  logic [DivDenW-1:0] den6_q;

  logic dry5, sat5;
  assign dry5 = !d1_ovf && (d1_q < noise_thr_q);
  assign sat5 = d1_ovf || (d1_q >= supply_q) || (series_res_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= d1_v;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl5_q   <= '{bad: d1_fl.bad, dry: dry5, sat: sat5};
      diff5_q <= supply_q - d1_q;
      kv5_q   <= cell_const_q * d1_q;
      fl6_q   <= fl5_q;
      num6_q  <= DivNumW'(kv5_q) * DivNumW'(CondGain);
      den6_q  <= DivDenW'(diff5_q) * DivDenW'(series_res_q);
    end
  end

  // ---------------- divider 2: raw conductivity ----------------
  logic             d2_v;
  logic [DivQW-1:0] d2_q;
  logic             d2_ovf;
  bcc_flags_t       d2_fl;

  bcc_udiv u_div_cond (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (den6_q),
    .side_i  (fl6_q),
    .valid_o (d2_v),
    .quot_o  (d2_q),
    .ovf_o   (d2_ovf),
    .side_o  (d2_fl)
  );

  // ---------------- S7: band correction, saturation ----------------
  logic        v7_q;
  bcc_flags_t  fl7_q;
  logic [15:0] c7_q;
  logic        over7_q;

  // ---------------- output register: class and final mux ----------------
  logic [15:0]  cond_q;
  brine_class_e cls_q;
  logic         oor_q;
  logic         vout_q;

  logic [16:0]  corr7;
  assign corr7 = correct_band(d2_q);

  brine_class_e cls_d;
  logic [15:0]  cond_d;
  logic         oor_d;

  always_comb begin
    cond_d = c7_q;
    cls_d  = over7_q ? CLASS_UNKNOWN : classify(c7_q);
    oor_d  = over7_q;
    if (fl7_q.bad) begin
      cond_d = '0;
      cls_d  = CLASS_UNKNOWN;
      oor_d  = 1'b1;
    end else if (fl7_q.dry) begin
      cond_d = '0;
      cls_d  = CLASS_UNKNOWN;
      oor_d  = 1'b0;
    end else if (fl7_q.sat) begin
      cond_d = Sat16;
      cls_d  = CLASS_UNKNOWN;
      oor_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v7_q   <= d2_v;
      vout_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl7_q   <= d2_fl;
      over7_q <= d2_ovf || corr7[16];
      c7_q    <= (d2_ovf || corr7[16]) ? Sat16 : corr7[15:0];
      cond_q  <= cond_d;
      cls_q   <= cls_d;
      oor_q   <= oor_d;
    end
  end

  assign m_axis_tvalid = vout_q;
  assign m_axis_tdata  = {3'b000, oor_q, (cls_q != CLASS_UNKNOWN), cls_q, cond_q};

  // ---------------- checks ----------------
  a_known_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19] == (m_axis_tdata[18:16] != CLASS_UNKNOWN)))
    else $error("class_known disagrees with brine_class");

  a_known_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[19]) |->
      (!m_axis_tdata[20] && m_axis_tdata[15:0] >= 16'd1120 && m_axis_tdata[15:0] <= 16'd4080))
    else $error("known class with flagged or out-of-band conductivity");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v7_q) && $stable(c7_q) && $stable(fl7_q)))
    else $error("pipeline advanced during output stall");

endmodule
`default_nettype wire

FILE: hdl/bcc_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with overflow flag.
// Depends on bcc_pkg.
`default_nettype none
module bcc_udiv
  import bcc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [DivDenW-1:0] den_i,
  input  wire bcc_flags_t         side_i,
  output logic                    valid_o,
  output logic [DivQW-1:0]        quot_o,
  output logic                    ovf_o,
  output bcc_flags_t              side_o
);

  logic               vld_q  [DivQW+1];
  logic [DivNumW-1:0] rem_q  [DivQW+1];
  logic [DivDenW-1:0] den_q  [DivQW+1];
  logic [DivQW-1:0]   quot_q [DivQW+1];
  logic               ovf_q  [DivQW+1];
  bcc_flags_t         side_q [DivQW+1];

  // entry stage: quotient fits in DivQW bits iff num < den << DivQW
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= ({{(DivExtW-DivNumW){1'b0}}, num_i} >=
                    ({{DivQW{1'b0}}, den_i} << DivQW));
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= DivQW; s++) begin : g_stage
    localparam int unsigned Bit = DivQW - s;
    logic [DivExtW-1:0] cand;
    logic               ge;
    assign cand = {{DivQW{1'b0}}, den_q[s-1]} << Bit;
    assign ge   = {{(DivExtW-DivNumW){1'b0}}, rem_q[s-1]} >= cand;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (rem_q[s-1] - cand[DivNumW-1:0]) : rem_q[s-1];
        den_q[s]  <= den_q[s-1];
        quot_q[s] <= quot_q[s-1] | ({{(DivQW-1){1'b0}}, ge} << Bit);
        ovf_q[s]  <= ovf_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[DivQW];
  assign quot_o  = quot_q[DivQW];
  assign ovf_o   = ovf_q[DivQW];
  assign side_o  = side_q[DivQW];

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for brine_conductivity_classifier.
// A scoreboard class predicts each result from the accepted inputs; plain tasks
// drive the input stream and config port. Depends on bcc_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bcc_pkg::*;

  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 60;     // longer than the pipe
  localparam int unsigned HoldOff       = 300;    // long receiver stall

  typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [15:0]  cond;
    brine_class_e cls;
    logic         known;
    logic         oor;
  } reading_t;

  // Predicts each reading and holds the ones not yet seen on the output.
  class reading_board;
    reading_t    pending_q[$];
    int unsigned errors;
    logic [15:0] alpha;
    logic [11:0] t_ref;
    logic [16:0] v_noise;
    logic [15:0] k_cell;
    logic [19:0] r_series;
    logic [16:0] v_supply;

    function new();
      errors   = 0;
      alpha    = 16'd1311;
      t_ref    = 12'd400;
      v_noise  = 17'd655;
      k_cell   = 16'd1800;
      r_series = 20'd10000;
      v_supply = 17'd108134;
    endfunction

    function void set_reg(logic [2:0] idx, logic [19:0] d);
      case (idx)
        RegTempCoef:  alpha    = d[15:0];
        RegRefTemp:   t_ref    = d[11:0];
        RegNoiseThr:  v_noise  = d[16:0];
        RegCellConst: k_cell   = d[15:0];
        RegSeriesRes: r_series = d[19:0];
        RegSupply:    v_supply = d[16:0];
        default: ;
      endcase
    endfunction

    // compute the reading an accepted sample must produce
    function void note_sample(logic [11:0] adc, logic [11:0] temp);
      longint   dt, comp, vc, num, den, c;
      reading_t r;
      dt = longint'($signed(temp)) - longint'($signed(t_ref));
      comp = (longint'(1) << CompShift) + longint'(alpha) * dt;
      r.cond = 16'd0;
      r.cls  = CLASS_UNKNOWN;
      r.oor  = 1'b0;
      if (comp <= 0) begin
        r.oor = 1'b1;
      end else begin
        vc = ((longint'(adc) * longint'(v_supply)) << CompShift)
             / (longint'(AdcFullScale) * comp);
        if (vc < longint'(v_noise)) begin
          r.cond = 16'd0;  // dry cell
        end else if (vc >= longint'(v_supply) || r_series == 0) begin
          r.cond = 16'hFFFF;
          r.oor  = 1'b1;
        end else begin
          num = 64'd16000 * longint'(k_cell) * vc;
          den = (longint'(v_supply) - vc) * longint'(r_series);
          c = num / den;
          // first matching band only
          if (c >= 1312 && c <= 1488)      c = c - 96;
          else if (c >= 1488 && c <= 1600) c = c + 197;
          else if (c >= 1584 && c <= 1760) c = c + 352;
          else if (c >= 1760 && c <= 1904) c = c + 800;
          else if (c >= 1920 && c <= 2000) c = c + 1763;
          else if (c >= 2000 && c <= 2160) c = c + 1874;
          if (c < 0) c = 0;
          if (c > 65535) begin
            c = 65535;
            r.oor = 1'b1;
          end
          r.cond = c[15:0];
          if (c >= 1120 && c < 1440)       r.cls = CLASS_50G;
          else if (c >= 1440 && c < 1842)  r.cls = CLASS_80G;
          else if (c >= 1842 && c < 2332)  r.cls = CLASS_100G;
          else if (c >= 2332 && c < 3159)  r.cls = CLASS_150G;
          else if (c >= 3159 && c < 3712)  r.cls = CLASS_300G;
          else if (c >= 3712 && c <= 4080) r.cls = CLASS_400G;
        end
      end
      r.known = (r.cls != CLASS_UNKNOWN);
      pending_q.push_back(r);
    endfunction

    function void check_reading(logic [23:0] d);
      reading_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[15:0] !== e.cond) begin
        $display("%0t: conductivity expected %0d actual %0d", $time, e.cond, d[15:0]);
        errors++;
      end
      if (d[18:16] !== e.cls) begin
        $display("%0t: brine_class expected %0d actual %0d", $time, e.cls, d[18:16]);
        errors++;
      end
      if (d[19] !== e.known) begin
        $display("%0t: class_known expected %b actual %b", $time, e.known, d[19]);
        errors++;
      end
      if (d[20] !== e.oor) begin
        $display("%0t: out_of_range expected %b actual %b", $time, e.oor, d[20]);
        errors++;
      end
      if (d[23:21] !== 3'b000) begin
        $display("%0t: pad bits expected 000 actual %b", $time, d[23:21]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [11:0] adc_sample, [23:12] temp_reading
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [15:0] conductivity, [18:16] brine_class,
                                    // [19] class_known, [20] out_of_range

  reading_board board = new();
  idle_mode_e   idle_mode = IDLE_NONE;
  bit           hold_req = 1'b0;
  int unsigned  hold_cnt = 0;
  int unsigned  cycle_cnt = 0;

  brine_conductivity_classifier i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: check each transaction, then pick the next tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_reading(m_axis_tdata);
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      // long stall so the pipe fills and input backs up
      hold_req = 1'b0;
      hold_cnt = HoldOff;
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RX:   m_axis_tready <= ($urandom_range(0, 99) >= 49);
        IDLE_BOTH: m_axis_tready <= ($urandom_range(0, 99) >= 21);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  // one input transaction; a gap lowers tvalid once, then waits
  task automatic send_sample(logic [11:0] adc, logic [11:0] temp);
    int unsigned gap;
    gap = 0;
    if (idle_mode == IDLE_TX && $urandom_range(0, 99) < 49) gap = $urandom_range(1, 4);
    if (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 21) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {temp, adc};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(adc, temp);
  endtask

  task automatic random_sample();
    logic [11:0] adc;
    int          t;
    // bias half the samples toward the band and class window
    if ($urandom_range(0, 1)) begin
      adc = 12'($urandom_range(1100, 2500));
      t   = int'($signed(board.t_ref)) + $urandom_range(0, 160) - 80;
      if (t < -880) t = -880;
      if (t > 2000) t = 2000;
    end else begin
      adc = 12'($urandom_range(0, 4095));
      t   = $urandom_range(0, 2880) - 880;
    end
    send_sample(adc, 12'(t));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_reg(idx, d);
  endtask

  task automatic load_cfg(int a, int rt, int nt, int k, int rs, int sv);
    write_reg(RegTempCoef,  20'(a));
    write_reg(RegRefTemp,   {8'd0, 12'(rt)});
    write_reg(RegNoiseThr,  20'(nt));
    write_reg(RegCellConst, 20'(k));
    write_reg(RegSeriesRes, 20'(rs));
    write_reg(RegSupply,    20'(sv));
  endtask

  task automatic run_phase(idle_mode_e m, bit pressure);
    idle_mode = m;
    for (int i = 0; i < ItemsPerPhase; i++) begin
      if (pressure && i == 10) hold_req = 1'b1;
      random_sample();
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config: field extremes and every special case
    send_sample(12'd0,    12'd400);                // dry: zero sample
    send_sample(12'd4095, 12'd400);                // full scale, saturates
    send_sample(12'd4000, 12'd400);                // corrected value over range
    send_sample(12'd1000, 12'(-880));              // compensation not positive
    send_sample(12'd4095, 12'(-880));
    send_sample(12'd2000, 12'd2000);               // hottest reading
    send_sample(12'd4095, 12'd2000);
    send_sample(12'd20,   12'd400);                // near noise threshold
    for (int a = 1150; a <= 2350; a += 80) send_sample(12'(a), 12'd400);  // bands/classes
    wait_idle();

    run_phase(IDLE_NONE, 1'b0);

    // low extremes
    load_cfg(0, -880, 0, 1, 1, 131071);
    send_sample(12'd0, 12'(-880));
    send_sample(12'd4095, 12'd2000);
    run_phase(IDLE_TX, 1'b0);

    // moderate config near defaults
    load_cfg(2000, 320, 1000, 1800, 10000, 108134);
    run_phase(IDLE_RX, 1'b0);

    // high extremes
    load_cfg(65535, 2000, 131071, 65535, 1000000, 1);
    send_sample(12'd4095, 12'(-880));
    send_sample(12'd4095, 12'd2000);
    run_phase(IDLE_BOTH, 1'b0);

    // back to reset values, with a long output stall
    load_cfg(1311, 400, 655, 1800, 10000, 108134);
    run_phase(IDLE_NONE, 1'b1);

    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
